@@ design/cfd_pkg.sv @@
// ----------------------------------------------------------------------------
// cfd_pkg: shared types and constants of the checked frame deframer
// Holds store geometry, framing bytes, the result record and helper functions.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int STORE_DEPTH    = 256;
    localparam int MAX_PAYLOAD    = 128;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int CNT_W          = $clog2(STORE_DEPTH + 1);
    localparam int FRAME_OVERHEAD = 5;
    localparam int WORD_BYTES     = 4;
    localparam int MAX_WORDS      = 32;
    localparam int Q_DEPTH        = 4;
    localparam int QP_W           = $clog2(Q_DEPTH);
    localparam int QC_W           = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] HEAD_BYTE = 8'hA5;
    localparam logic [7:0] TAIL_BYTE = 8'h49;

    // configuration register indexes
    localparam logic CFG_LINK_UP = 1'b0;
    localparam logic CFG_TEMP    = 1'b1;

    typedef struct packed {
        logic [7:0] link_cmd;
        logic [7:0] temp_cmd;
    } cfg_t;

    typedef struct packed {
        logic        link;
        logic [31:0] temp;
        logic        last;
        logic [31:0] word;
        logic [4:0]  widx;
        logic [7:0]  cmd;
    } res_t;

    // circular store address of a sum that stays below twice the depth
    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [CNT_W:0] s);
        logic [CNT_W:0] d;
        d = s;
        if (s >= (CNT_W+1)'(STORE_DEPTH)) d = s - (CNT_W+1)'(STORE_DEPTH);
        return d[ADDR_W-1:0];
    endfunction

    function automatic logic length_ok(input logic [7:0] len);
        logic ok;
        ok = (len != 8'd0) && (len[1:0] == 2'b00)
            && (int'(len) <= MAX_PAYLOAD)
            && (int'(len) <= MAX_WORDS * WORD_BYTES)
            && (int'(len) + FRAME_OVERHEAD <= STORE_DEPTH);
        return ok;
    endfunction

endpackage

@@ design/checked_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// checked_frame_deframer: head/length/checksum/tail frame extractor
// Finds 0xA5-headed frames in a byte stream and emits their payload words.
// ----------------------------------------------------------------------------
// Scan: each store read in the scanner takes a wait state and then a use state,
//   since the store read data is registered.
// Flow: a new byte is taken only in the idle state, once its scan is done; each word
//   is built from four store reads and pushed when the queue is not full.
// Reset: aresetn low clears the store count, flags, temperature and queue;
//   configuration returns to link-up 1, temperature 2. No clearing pass.
module checked_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // payload words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] frame_command, [12:8] word_index,
                                   // [44:13] payload_word, [76:45] temperature_bits,
                                   // [77] motor_link_up, [79:78] zero
    output logic        m_tlast,   // last_word
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import cfd_pkg::*;

    cfg_t cfg_reg;
    logic q_full;
    logic push;
    res_t push_res;
    res_t m_res;

    // Configuration: take a write whenever enabled; the user must write only while idle (not enforced here).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.link_cmd <= 8'd1;
            cfg_reg.temp_cmd <= 8'd2;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_LINK_UP: cfg_reg.link_cmd <= cfg_wdata;
                CFG_TEMP:    cfg_reg.temp_cmd <= cfg_wdata;
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front: store every beat, scan, and push the words of each good frame.
    cfd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg_reg),
        .push     (push),
        .push_res (push_res),
        .q_full   (q_full)
    );

    // Back: hold words until the sink takes each beat.
    cfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_res (push_res),
        .q_full   (q_full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {2'b00, m_res.link, m_res.temp, m_res.word, m_res.widx, m_res.cmd};
    assign m_tlast = m_res.last;

endmodule

@@ design/cfd_front.sv @@
// ----------------------------------------------------------------------------
// cfd_front: byte store and frame scanner
// Stores link bytes, scans for checked frames and hands payload words to the queue.
// ----------------------------------------------------------------------------
module cfd_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  cfd_pkg::cfg_t cfg,
    output logic          push,
    output cfd_pkg::res_t push_res,
    input  logic          q_full
);
    import cfd_pkg::*;

    typedef enum logic [4:0] {
        F_IDLE, F_CHECK, F_HWAIT, F_HUSE, F_LWAIT, F_LUSE, F_TWAIT, F_TUSE,
        F_SWAIT, F_SUSE, F_CWAIT, F_CUSE, F_MWAIT, F_MUSE, F_WWAIT, F_WUSE, F_PUSH
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic [ADDR_W-1:0]  start_reg, start_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   fs_reg, fs_next;
    logic [5:0]         words_reg, words_next;
    logic [7:0]         sum_reg, sum_next;
    logic [5:0]         n_reg, n_next;
    logic [7:0]         cmd_reg, cmd_next;
    logic [31:0]        word_reg, word_next;
    logic [1:0]         bcnt_reg, bcnt_next;
    logic [4:0]         widx_reg, widx_next;
    logic [31:0]        temp_reg, temp_next;
    logic               link_reg, link_next;

    logic [CNT_W-1:0]   drop_amt;
    logic               inc;
    logic [7:0]         rd_data_reg;
    logic [ADDR_W-1:0]  raddr, waddr;
    logic [7:0]         mem [STORE_DEPTH];
    logic               last_w;
    logic               temp_hit;

    assign raddr  = wrap_addr((CNT_W+1)'(start_reg) + (CNT_W+1)'(pos_reg));
    assign waddr  = wrap_addr((CNT_W+1)'(start_reg) + (CNT_W+1)'(count_reg));
    assign last_w = ((6'(widx_reg) + 6'd1) == words_reg);
    assign temp_hit = (widx_reg == 5'd0) && (cmd_reg == cfg.temp_cmd);

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mem[waddr] <= s_tdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        fs_next    = fs_reg;
        words_next = words_reg;
        sum_next   = sum_reg;
        n_next     = n_reg;
        cmd_next   = cmd_reg;
        word_next  = word_reg;
        bcnt_next  = bcnt_reg;
        widx_next  = widx_reg;
        temp_next  = temp_reg;
        link_next  = link_reg;
        drop_amt   = '0;
        inc        = 1'b0;
        s_tready   = 1'b0;
        push       = 1'b0;
        push_res   = '0;
        push_res.cmd  = cmd_reg;
        push_res.widx = widx_reg;
        push_res.word = word_reg;
        push_res.last = last_w;
        push_res.temp = temp_hit ? word_reg : temp_reg;
        push_res.link = link_reg;

        case (state_reg)
            F_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    inc = 1'b1;
                    // full store: overwrite the oldest byte
                    if (count_reg == CNT_W'(STORE_DEPTH)) drop_amt = CNT_W'(1);
                    n_next     = '0;
                    state_next = F_CHECK;
                end
            end
            F_CHECK: begin
                if (count_reg < CNT_W'(FRAME_OVERHEAD)) begin
                    state_next = F_IDLE;
                end else begin
                    pos_next   = '0;
                    state_next = F_HWAIT;
                end
            end
            F_HWAIT: state_next = F_HUSE;
            F_HUSE: begin
                if (rd_data_reg == HEAD_BYTE) begin
                    if (pos_reg == '0) begin
                        pos_next   = CNT_W'(2);
                        state_next = F_LWAIT;
                    end else begin
                        drop_amt   = pos_reg;
                        state_next = F_CHECK;
                    end
                end else if (pos_reg + CNT_W'(1) == count_reg) begin
                    // no head anywhere: keep only the newest byte
                    drop_amt   = count_reg - CNT_W'(1);
                    state_next = F_CHECK;
                end else begin
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = F_HWAIT;
                end
            end
            F_LWAIT: state_next = F_LUSE;
            F_LUSE: begin
                if (!length_ok(rd_data_reg)) begin
                    drop_amt   = CNT_W'(1);
                    state_next = F_CHECK;
                end else begin
                    fs_next    = CNT_W'(11'(rd_data_reg) + 11'(FRAME_OVERHEAD));
                    words_next = rd_data_reg[7:2];
                    if (11'(count_reg) < 11'(rd_data_reg) + 11'(FRAME_OVERHEAD)) begin
                        state_next = F_IDLE;
                    end else begin
                        pos_next   = CNT_W'(11'(rd_data_reg) + 11'(FRAME_OVERHEAD - 1));
                        state_next = F_TWAIT;
                    end
                end
            end
            F_TWAIT: state_next = F_TUSE;
            F_TUSE: begin
                if (rd_data_reg != TAIL_BYTE) begin
                    drop_amt   = CNT_W'(1);
                    state_next = F_CHECK;
                end else begin
                    sum_next   = '0;
                    pos_next   = '0;
                    state_next = F_SWAIT;
                end
            end
            F_SWAIT: state_next = F_SUSE;
            F_SUSE: begin
                sum_next = sum_reg + rd_data_reg;
                if (11'(pos_reg) + 11'd3 == 11'(fs_reg)) begin
                    pos_next   = fs_reg - CNT_W'(2);
                    state_next = F_CWAIT;
                end else begin
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = F_SWAIT;
                end
            end
            F_CWAIT: state_next = F_CUSE;
            F_CUSE: begin
                if (sum_reg != rd_data_reg) begin
                    drop_amt   = CNT_W'(1);
                    state_next = F_CHECK;
                end else if (n_reg != '0
                        && 7'(n_reg) + 7'(words_reg) > 7'(MAX_WORDS)) begin
                    // hold the frame for a later byte
                    state_next = F_IDLE;
                end else begin
                    pos_next   = CNT_W'(1);
                    state_next = F_MWAIT;
                end
            end
            F_MWAIT: state_next = F_MUSE;
            F_MUSE: begin
                cmd_next = rd_data_reg;
                if (rd_data_reg == cfg.link_cmd) link_next = 1'b1;
                pos_next   = CNT_W'(3);
                bcnt_next  = '0;
                widx_next  = '0;
                state_next = F_WWAIT;
            end
            F_WWAIT: state_next = F_WUSE;
            F_WUSE: begin
                word_next = {rd_data_reg, word_reg[31:8]};
                pos_next  = pos_reg + CNT_W'(1);
                bcnt_next = bcnt_reg + 2'd1;
                state_next = (bcnt_reg == 2'd3) ? F_PUSH : F_WWAIT;
            end
            F_PUSH: begin
                if (!q_full) begin
                    push = 1'b1;
                    if (temp_hit) temp_next = word_reg;
                    n_next    = n_reg + 6'd1;
                    widx_next = widx_reg + 5'd1;
                    if (last_w) begin
                        drop_amt   = fs_reg;
                        state_next = F_CHECK;
                    end else begin
                        state_next = F_WWAIT;
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase

        start_next = wrap_addr((CNT_W+1)'(start_reg) + (CNT_W+1)'(drop_amt));
        count_next = count_reg - drop_amt + CNT_W'(inc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            start_reg <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            n_reg     <= '0;
            temp_reg  <= '0;
            link_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            n_reg     <= n_next;
            temp_reg  <= temp_next;
            link_reg  <= link_next;
        end
        pos_reg   <= pos_next;
        fs_reg    <= fs_next;
        words_reg <= words_next;
        cmd_reg   <= cmd_next;
        word_reg  <= word_next;
        bcnt_reg  <= bcnt_next;
        widx_reg  <= widx_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STORE_DEPTH))
        else $error("store count beyond depth");
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == F_CHECK)
        else $error("accepted byte not scanned");
    a_head_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == F_HUSE |-> pos_reg < count_reg)
        else $error("head search beyond buffered bytes");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("push into full queue");

endmodule

@@ design/cfd_back.sv @@
// ----------------------------------------------------------------------------
// cfd_back: result queue and output stage
// Buffers payload words from the scanner and presents them on the result stream.
// ----------------------------------------------------------------------------
module cfd_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cfd_pkg::res_t push_res,
    output logic          q_full,
    output logic          m_tvalid,
    input  logic          m_tready,
    output cfd_pkg::res_t m_res
);
    import cfd_pkg::*;

    res_t            q_mem [Q_DEPTH];
    logic [QP_W-1:0] wptr_reg, rptr_reg;
    logic [QC_W-1:0] qcount_reg;
    logic            pop;

    assign q_full   = (qcount_reg == QC_W'(Q_DEPTH));
    assign m_tvalid = (qcount_reg != '0);
    assign m_res    = q_mem[rptr_reg];
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (push) q_mem[wptr_reg] <= push_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg   <= '0;
            rptr_reg   <= '0;
            qcount_reg <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + QP_W'(1);
            if (pop)  rptr_reg <= rptr_reg + QP_W'(1);
            qcount_reg <= qcount_reg + QC_W'(push) - QC_W'(pop);
        end
    end

    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qcount_reg <= QC_W'(Q_DEPTH))
        else $error("queue count beyond depth");
    a_q_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        qcount_reg == '0 |-> wptr_reg == rptr_reg)
        else $error("empty queue with split pointers");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for checked_frame_deframer
// Streams link bytes (well-formed frames, corrupted frames and line noise)
// into the block. A scoreboard rebuilds the frame search on its own byte
// store, queues the expected payload words and checks every output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import cfd_pkg::*;

    localparam int SETTLE_CYCLES = 2500;   // worst rescan plus a full frame
    localparam int ITEM_TARGET   = 330;

    typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_TAIL, FR_BAD_LEN} frame_kind_t;

    typedef struct {
        logic [7:0]  cmd;
        logic [4:0]  widx;
        logic [31:0] word;
        logic        last;
        logic [31:0] temp;
        logic        link;
    } word_rec_t;

    // Frame search scoreboard: mirrors the byte store and the status flags.
    class deframe_scoreboard;
        logic [7:0]  ring[STORE_DEPTH];
        int          head_pos;
        int          fill;
        logic [31:0] temp_word;
        logic        link_up;
        logic [7:0]  link_cmd;
        logic [7:0]  temp_cmd;
        word_rec_t   pending_words[$];
        int          errors;
        int          words_seen;

        function void clear();
            head_pos = 0; fill = 0; temp_word = '0; link_up = 1'b0;
            link_cmd = 8'd1; temp_cmd = 8'd2;
            errors = 0; words_seen = 0;
            pending_words.delete();
        endfunction

        function logic [7:0] at(int p);
            return ring[(head_pos + p) % STORE_DEPTH];
        endfunction

        function void discard(int n);
            if (n > fill) n = fill;
            head_pos = (head_pos + n) % STORE_DEPTH;
            fill -= n;
        endfunction

        function logic [31:0] word_from(int p);
            return {at(p + 3), at(p + 2), at(p + 1), at(p)};
        endfunction

        // Accept one link byte and queue every payload word it releases.
        function void note_byte(logic [7:0] b);
            int        h, len, fsize, nwords, emitted;
            logic [7:0] acc, cmd;
            word_rec_t r;
            emitted = 0;
            if (fill >= STORE_DEPTH) discard(1);
            ring[(head_pos + fill) % STORE_DEPTH] = b;
            fill++;
            while (fill >= FRAME_OVERHEAD) begin
                h = 0;
                while (h < fill && at(h) != HEAD_BYTE) h++;
                if (h == fill) begin
                    discard(fill - 1);
                    continue;
                end
                if (h > 0) begin
                    discard(h);
                    continue;
                end
                len = at(2);
                if (len == 0 || len % WORD_BYTES != 0 || len > MAX_PAYLOAD ||
                    len > MAX_WORDS * WORD_BYTES || len + FRAME_OVERHEAD > STORE_DEPTH) begin
                    discard(1);
                    continue;
                end
                fsize = FRAME_OVERHEAD + len;
                if (fill < fsize) break;
                if (at(fsize - 1) != TAIL_BYTE) begin
                    discard(1);
                    continue;
                end
                acc = '0;
                for (int i = 0; i < fsize - 2; i++) acc = acc + at(i);
                if (acc != at(fsize - 2)) begin
                    discard(1);
                    continue;
                end
                nwords = len / WORD_BYTES;
                // hold a frame that would overrun one step's word budget
                if (emitted > 0 && emitted + nwords > MAX_WORDS) break;
                cmd = at(1);
                if (cmd == link_cmd) link_up = 1'b1;
                if (cmd == temp_cmd) temp_word = word_from(3);
                for (int w = 0; w < nwords; w++) begin
                    r.cmd  = cmd;
                    r.widx = w[4:0];
                    r.word = word_from(3 + w * WORD_BYTES);
                    r.last = (w + 1 == nwords);
                    r.temp = temp_word;
                    r.link = link_up;
                    pending_words = {pending_words, r};
                    emitted++;
                end
                discard(fsize);
            end
        endfunction

        // Compare one output beat against the oldest queued word.
        function void check_word(logic [79:0] d, logic l);
            word_rec_t e;
            words_seen++;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected beat tdata=%h tlast=%b", $time, d, l);
                errors++;
                return;
            end
            e = pending_words.pop_front();
            if (d[7:0] !== e.cmd) begin
                $display("%0t: frame_command exp %h got %h", $time, e.cmd, d[7:0]);
                errors++;
            end
            if (d[12:8] !== e.widx) begin
                $display("%0t: word_index exp %0d got %0d", $time, e.widx, d[12:8]);
                errors++;
            end
            if (d[44:13] !== e.word) begin
                $display("%0t: payload_word exp %h got %h", $time, e.word, d[44:13]);
                errors++;
            end
            if (l !== e.last) begin
                $display("%0t: last_word exp %b got %b", $time, e.last, l);
                errors++;
            end
            if (d[76:45] !== e.temp) begin
                $display("%0t: temperature_bits exp %h got %h", $time, e.temp, d[76:45]);
                errors++;
            end
            if (d[77] !== e.link) begin
                $display("%0t: motor_link_up exp %b got %b", $time, e.link, d[77]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = CFG_LINK_UP;
    logic [7:0]  cfg_wdata = '0;

    deframe_scoreboard sb;
    int bytes_taken = 0;

    checked_frame_deframer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Sample both channels at the rising edge; note input before checking output.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_byte(s_tdata);
                bytes_taken++;
            end
            if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 19);
        if (p < 10) return 0;
        if (p < 18) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // Result side back-pressure: bursts of ready with random stalls between.
    initial begin
        int run_len, stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_tready <= 1'b1;
            run_len = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 10);
            repeat (run_len) @(negedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    // Present one byte and hold it until the handshake; called at a falling edge.
    task automatic send_byte(input logic [7:0] b);
        int gap, target;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        target = bytes_taken + 1;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(negedge aclk);
        while (bytes_taken < target) @(negedge aclk);
    endtask

    // Build one frame, optionally corrupted, and stream it out.
    task automatic send_frame(input logic [7:0] cmd, input int len, input frame_kind_t kind);
        logic [7:0] q[$];
        logic [7:0] acc, b;
        int         bad_lens[5] = '{0, 3, 130, 132, 252};
        if (kind == FR_BAD_LEN) begin
            q = {HEAD_BYTE, cmd, 8'(bad_lens[$urandom_range(0, 4)])};
            repeat ($urandom_range(1, 6)) q = {q, 8'($urandom)};
        end else begin
            q = {HEAD_BYTE, cmd, 8'(len)};
            repeat (len) q = {q, 8'($urandom)};
            acc = '0;
            foreach (q[i]) acc = acc + q[i];
            if (kind == FR_BAD_SUM) acc = acc ^ (8'd1 << $urandom_range(0, 7));
            q = {q, acc};
            b = TAIL_BYTE;
            if (kind == FR_BAD_TAIL) b = TAIL_BYTE ^ 8'($urandom_range(1, 255));
            q = {q, b};
        end
        foreach (q[i]) send_byte(q[i]);
    endtask

    // Stop sending, wait for every queued word, then let the scanner settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending_words.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        while (!s_tready) @(negedge aclk);
    endtask

    // Write both command registers while the block is idle.
    task automatic set_commands(input logic [7:0] link_cmd, input logic [7:0] temp_cmd);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_LINK_UP;
        cfg_wdata <= link_cmd;
        @(negedge aclk);
        cfg_addr  <= CFG_TEMP;
        cfg_wdata <= temp_cmd;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.link_cmd = link_cmd;
        sb.temp_cmd = temp_cmd;
        @(negedge aclk);
    endtask

    // Random traffic: mostly good frames with small payloads, commands
    // biased toward the configured ones, plus corrupted frames and noise.
    task automatic random_traffic(input int byte_goal, input int word_goal);
        int         pick, len;
        logic [7:0] cmd;
        while (bytes_taken < byte_goal || sb.words_seen + sb.pending_words.size() < word_goal)
        begin
            pick = $urandom_range(0, 9);
            case ($urandom_range(0, 3))
                0: cmd = sb.link_cmd;
                1: cmd = sb.temp_cmd;
                default: cmd = 8'($urandom);
            endcase
            len = ($urandom_range(0, 30) == 0) ? MAX_PAYLOAD : 4 * $urandom_range(1, 4);
            if (pick < 7) begin
                send_frame(cmd, len, FR_GOOD);
            end else if (pick == 7) begin
                send_frame(cmd, len, $urandom_range(0, 1) ? FR_BAD_SUM : FR_BAD_TAIL);
            end else if (pick == 8) begin
                send_frame(cmd, len, FR_BAD_LEN);
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: defaults, then the special cases one by one.
        send_frame(8'd1, 4, FR_GOOD);                     // link-up command
        send_frame(8'd2, 8, FR_GOOD);                     // temperature command
        send_byte(8'h00); send_byte(8'hFF);               // noise, no head
        send_byte(8'h12); send_byte(8'h34); send_byte(8'h56);
        send_frame(8'hFF, 4, FR_BAD_LEN);                 // bad length
        send_frame(8'h00, 4, FR_BAD_SUM);                 // bad checksum
        send_frame(8'h80, 4, FR_BAD_TAIL);                // bad tail
        send_byte(HEAD_BYTE); send_byte(HEAD_BYTE);       // head-like noise
        send_frame(8'h7F, MAX_PAYLOAD, FR_GOOD);          // longest payload
        drain();

        // Extreme register settings, then random settings.
        set_commands(8'h00, 8'hFF);
        send_frame(8'h00, 4, FR_GOOD);
        send_frame(8'hFF, 4, FR_GOOD);
        random_traffic(140, 40);
        drain();                                          // hold off until all words arrive

        set_commands(8'hFF, 8'hFF);
        random_traffic(230, 45);
        drain();

        set_commands(8'($urandom), 8'($urandom));
        random_traffic(ITEM_TARGET, 50);

        drain();
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Generous watchdog against a hung handshake.
    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
